### hw/rtl/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types and constants of the sparse-set component store.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int ACT_W     = 2;
    localparam int TYPE_W    = 4;
    localparam int ENT_W     = 10;
    localparam int SLOT_W    = 8;
    localparam int PAY_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CAP_W     = 9;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD      = 2'd0,
        ACT_REMOVE   = 2'd1,
        ACT_GET_ENT  = 2'd2,
        ACT_GET_SLOT = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic lookup;
        logic rm_first;
        logic get_read;
        logic finish;
        logic rm_finish;
        logic get_finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic rm_hit;
        logic get_hit;
        logic out_free;
    } ctl_sts_t;

endpackage

### hw/rtl/ssc_ram.sv
// ----------------------------------------------------------------------------
// ssc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/ssc_ctrl.sv
// ----------------------------------------------------------------------------
// ssc_ctrl
// Sequencer: map clearing pass, operation lookup, commit and response hand-off.
// ----------------------------------------------------------------------------
module ssc_ctrl import ssc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_LOOK   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_REMOVE = 6'b010000,
        S_GET    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd.lookup = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (sts.rm_hit) begin
                    cmd.rm_first = 1'b1;
                    state_next   = S_REMOVE;
                end else if (sts.get_hit) begin
                    cmd.get_read = 1'b1;
                    state_next   = S_GET;
                end else if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REMOVE: begin
                if (sts.out_free) begin
                    cmd.rm_finish = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_GET: begin
                if (sts.out_free) begin
                    cmd.get_finish = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/ssc_datapath.sv
// ----------------------------------------------------------------------------
// ssc_datapath
// Sparse map, dense stores, type counts, capacity register and result register.
// ----------------------------------------------------------------------------
module ssc_datapath import ssc_pkg::*; #(
    parameter int NUM_TYPES     = 8,
    parameter int ENTITY_SLOTS  = 1024,
    parameter int DENSE_DEPTH   = 256,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    input  logic [ACT_W-1:0]  in_action,
    input  logic [TYPE_W-1:0] in_type,
    input  logic [ENT_W-1:0]  in_entity,
    input  logic [SLOT_W-1:0] in_slot,
    input  logic [PAY_W-1:0]  in_payload,
    input  ctl_cmd_t          cmd,
    output ctl_sts_t          sts,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [STAT_W-1:0] res_status,
    output logic [SLOT_W-1:0] res_slot,
    output logic [PAY_W-1:0]  res_payload,
    output logic              res_moved,
    output logic [ENT_W-1:0]  res_ment
);

    localparam int PW        = (PAYLOAD_WIDTH > PAY_W) ? PAY_W : PAYLOAD_WIDTH;
    localparam int TW        = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int EW        = $clog2(ENTITY_SLOTS);
    localparam int SW        = $clog2(DENSE_DEPTH);
    localparam int CNW       = $clog2(DENSE_DEPTH + 1);
    localparam int MW        = SW + 1;
    localparam int MAP_DEPTH = NUM_TYPES * ENTITY_SLOTS;
    localparam int DNS_DEPTH = NUM_TYPES * DENSE_DEPTH;
    localparam int MAW       = $clog2(MAP_DEPTH);
    localparam int DAW       = $clog2(DNS_DEPTH);

    // operation registers
    action_t           act_reg;
    logic [TYPE_W-1:0] typ_reg;
    logic [ENT_W-1:0]  ent_reg;
    logic [SLOT_W-1:0] sreq_reg;
    logic [PW-1:0]     pay_reg;
    logic [PW-1:0]     last_pay_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [MAW-1:0]    clr_cnt_reg;
    logic [CNW-1:0]    count_reg [NUM_TYPES];

    logic              m_valid_reg;
    status_t           o_status_reg;
    logic [SW-1:0]     o_slot_reg;
    logic [PW-1:0]     o_pay_reg;
    logic              o_moved_reg;
    logic [EW-1:0]     o_ment_reg;

    // RAM ports
    logic           map_we, map_re, ent_we, ent_re, pay_we, pay_re;
    logic [MAW-1:0] map_wa, map_ra;
    logic [MW-1:0]  map_wd, map_rd;
    logic [DAW-1:0] ent_wa, ent_ra, pay_wa, pay_ra;
    logic [EW-1:0]  ent_wd, ent_rd;
    logic [PW-1:0]  pay_wd, pay_rd;

    // derived values
    logic [TW-1:0]  typ_idx;
    logic [EW-1:0]  ent_idx;
    logic           type_ok, ent_ok, hit, full, sreq_ok, moved;
    logic [CNW-1:0] cnt;
    logic [SW-1:0]  last_slot, hit_slot;
    logic [9:0]     eff_lim;
    logic [MAW-1:0] mbase, map_addr, repl_addr;
    logic [DAW-1:0] dbase, last_addr, cnt_addr, sreq_addr, hit_addr;

    logic           res_load, cnt_inc, cnt_dec;
    status_t        r_status;
    logic [SW-1:0]  r_slot;
    logic [PW-1:0]  r_pay;
    logic           r_moved;
    logic [EW-1:0]  r_ment;

    assign typ_idx   = typ_reg[TW-1:0];
    assign ent_idx   = ent_reg[EW-1:0];
    assign type_ok   = 5'(typ_reg) < 5'(NUM_TYPES);
    assign ent_ok    = 11'(ent_reg) < 11'(ENTITY_SLOTS);
    assign cnt       = count_reg[typ_idx];
    assign hit       = map_rd[SW];
    assign hit_slot  = map_rd[SW-1:0];
    assign last_slot = SW'(cnt - CNW'(1));
    assign eff_lim   = ({1'b0, cap_reg} > 10'(DENSE_DEPTH)) ? 10'(DENSE_DEPTH)
                                                            : {1'b0, cap_reg};
    assign full      = 10'(cnt) >= eff_lim;
    assign sreq_ok   = 10'(sreq_reg) < 10'(cnt);
    assign moved     = ent_rd != ent_idx;

    assign mbase     = MAW'(32'(typ_idx) * 32'(ENTITY_SLOTS));
    assign map_addr  = mbase + MAW'(ent_idx);
    assign repl_addr = mbase + MAW'(ent_rd);
    assign dbase     = DAW'(32'(typ_idx) * 32'(DENSE_DEPTH));
    assign last_addr = dbase + DAW'(last_slot);
    assign cnt_addr  = dbase + DAW'(cnt);
    assign sreq_addr = dbase + DAW'(sreq_reg);
    assign hit_addr  = dbase + DAW'(hit_slot);

    assign sts.clr_last = clr_cnt_reg == MAW'(MAP_DEPTH - 1);
    assign sts.rm_hit   = type_ok && act_reg == ACT_REMOVE && ent_ok && hit
                          && cnt != '0;
    assign sts.get_hit  = type_ok && act_reg == ACT_GET_ENT && ent_ok && hit;
    assign sts.out_free = !m_valid_reg || m_tready;

    assign res_load = cmd.finish || cmd.rm_finish || cmd.get_finish;

    always_comb begin
        map_we   = 1'b0;
        map_wa   = map_addr;
        map_wd   = '0;
        map_re   = 1'b0;
        map_ra   = map_addr;
        ent_we   = 1'b0;
        ent_wa   = cnt_addr;
        ent_wd   = ent_idx;
        ent_re   = 1'b0;
        ent_ra   = last_addr;
        pay_we   = 1'b0;
        pay_wa   = cnt_addr;
        pay_wd   = pay_reg;
        pay_re   = 1'b0;
        pay_ra   = last_addr;
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        r_status = ST_OK;
        r_slot   = '0;
        r_pay    = '0;
        r_moved  = 1'b0;
        r_ment   = '0;

        if (cmd.clear) begin
            map_we = 1'b1;
            map_wa = clr_cnt_reg;
        end

        if (cmd.lookup) begin
            map_re = 1'b1;
            ent_re = 1'b1;
            pay_re = 1'b1;
            if (act_reg == ACT_GET_SLOT) begin
                pay_ra = sreq_addr;
            end
        end

        if (cmd.rm_first) begin
            map_we = 1'b1;
            pay_re = 1'b1;
            pay_ra = hit_addr;
        end

        if (cmd.get_read) begin
            pay_re = 1'b1;
            pay_ra = hit_addr;
        end

        if (cmd.finish) begin
            if (!type_ok) begin
                r_status = ST_REJECT;
            end else begin
                case (act_reg)
                    ACT_ADD: begin
                        if (!ent_ok) begin
                            r_status = ST_REJECT;
                        end else if (hit) begin
                            pay_we = 1'b1;
                            pay_wa = hit_addr;
                            r_slot = hit_slot;
                        end else if (full) begin
                            r_status = ST_REJECT;
                        end else begin
                            ent_we  = 1'b1;
                            pay_we  = 1'b1;
                            map_we  = 1'b1;
                            map_wd  = {1'b1, SW'(cnt)};
                            cnt_inc = 1'b1;
                            r_slot  = SW'(cnt);
                        end
                    end
                    ACT_GET_SLOT: begin
                        if (sreq_ok) begin
                            r_slot = SW'(sreq_reg);
                            r_pay  = pay_rd;
                        end else begin
                            r_status = ST_ABSENT;
                        end
                    end
                    default: begin
                        r_status = ST_ABSENT;
                    end
                endcase
            end
        end

        if (cmd.rm_finish) begin
            cnt_dec = 1'b1;
            r_slot  = hit_slot;
            r_pay   = pay_rd;
            r_moved = moved;
            r_ment  = moved ? ent_rd : ent_idx;
            if (moved) begin
                ent_we = 1'b1;
                ent_wa = hit_addr;
                ent_wd = ent_rd;
                pay_we = 1'b1;
                pay_wa = hit_addr;
                pay_wd = last_pay_reg;
                map_we = 1'b1;
                map_wa = repl_addr;
                map_wd = {1'b1, hit_slot};
            end
        end

        if (cmd.get_finish) begin
            r_slot = hit_slot;
            r_pay  = pay_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TYPES; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + MAW'(1);
            end
            if (cnt_inc) begin
                count_reg[typ_idx] <= cnt + CNW'(1);
            end else if (cnt_dec) begin
                count_reg[typ_idx] <= cnt - CNW'(1);
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg  <= action_t'(in_action);
            typ_reg  <= in_type;
            ent_reg  <= in_entity;
            sreq_reg <= in_slot;
            pay_reg  <= in_payload[PW-1:0];
        end
        if (cmd.rm_first) begin
            last_pay_reg <= pay_rd;
        end
        if (res_load) begin
            o_status_reg <= r_status;
            o_slot_reg   <= r_slot;
            o_pay_reg    <= r_pay;
            o_moved_reg  <= r_moved;
            o_ment_reg   <= r_ment;
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign res_status  = o_status_reg;
    assign res_slot    = SLOT_W'(o_slot_reg);
    assign res_payload = PAY_W'(o_pay_reg);
    assign res_moved   = o_moved_reg;
    assign res_ment    = ENT_W'(o_ment_reg);

    ssc_ram #(.WIDTH(MW), .DEPTH(MAP_DEPTH)) u_map_ram (
        .aclk    (aclk),
        .wr_en   (map_we),
        .wr_addr (map_wa),
        .wr_data (map_wd),
        .rd_en   (map_re),
        .rd_addr (map_ra),
        .rd_data (map_rd)
    );

    ssc_ram #(.WIDTH(EW), .DEPTH(DNS_DEPTH)) u_ent_ram (
        .aclk    (aclk),
        .wr_en   (ent_we),
        .wr_addr (ent_wa),
        .wr_data (ent_wd),
        .rd_en   (ent_re),
        .rd_addr (ent_ra),
        .rd_data (ent_rd)
    );

    ssc_ram #(.WIDTH(PW), .DEPTH(DNS_DEPTH)) u_pay_ram (
        .aclk    (aclk),
        .wr_en   (pay_we),
        .wr_addr (pay_wa),
        .wr_data (pay_wd),
        .rd_en   (pay_re),
        .rd_addr (pay_ra),
        .rd_data (pay_rd)
    );

endmodule

### hw/rtl/sparse_set_component_store_top.sv
// ----------------------------------------------------------------------------
// sparse_set_component_store_top
// Per-type sparse-set component store with swap-remove.
//
// s_ channel carries one request per transfer: action in s_tuser, the rest
// packed in s_tdata. m_ channel returns exactly one response per request,
// status in m_tuser. cfg_wr_en/cfg_wr_data write the shared capacity limit;
// write it only while no request is in flight.
// For add, get-by-slot and requests that miss or are rejected the response
// is loaded after the lookup read of the RAMs; remove and get-by-entity of a
// present entity load it only after the dependent reads of the sparse map
// RAM and then the dense payload RAM (registered read each).
// One request is in flight at a time; the next is taken the cycle after the
// response has been loaded.
// After reset the sparse map is swept clear, one entry per cycle, over all
// NUM_TYPES * ENTITY_SLOTS entries (8192 by default); s_tready stays low
// meanwhile. Counts reset to zero and the capacity limit to 256.
// A stalled m_ channel holds the response; the block finishes the current
// request's writes only once the output register is free.
// ----------------------------------------------------------------------------
module sparse_set_component_store_top import ssc_pkg::*; #(
    parameter int NUM_TYPES     = 8,
    parameter int ENTITY_SLOTS  = 1024,
    parameter int DENSE_DEPTH   = 256,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CAP_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // comp_type[3:0], entity_id[13:4], slot_in[21:14], payload_in[53:22], zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[1:0]
    input  logic [ACT_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // slot_out[7:0], payload_out[39:8], moved[40], moved_entity[50:41], zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STAT_W-1:0]    m_tuser
);

    ctl_cmd_t          cmd;
    ctl_sts_t          sts;
    logic [SLOT_W-1:0] res_slot;
    logic [PAY_W-1:0]  res_payload;
    logic              res_moved;
    logic [ENT_W-1:0]  res_ment;

    ssc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ssc_datapath #(
        .NUM_TYPES     (NUM_TYPES),
        .ENTITY_SLOTS  (ENTITY_SLOTS),
        .DENSE_DEPTH   (DENSE_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_action   (s_tuser),
        .in_type     (s_tdata[3:0]),
        .in_entity   (s_tdata[13:4]),
        .in_slot     (s_tdata[21:14]),
        .in_payload  (s_tdata[53:22]),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .res_status  (m_tuser),
        .res_slot    (res_slot),
        .res_payload (res_payload),
        .res_moved   (res_moved),
        .res_ment    (res_ment)
    );

    assign m_tdata = {5'd0, res_ment, res_moved, res_payload, res_slot};

endmodule
